/* hw/rtl/c8x_pkg.sv */
// shared types, constants and state codes for the chip8 instruction executor
package c8x_pkg;

    localparam int MemoryBytes  = 4096;
    localparam int ScreenWidth  = 64;
    localparam int ScreenHeight = 32;
    localparam int StackDepth   = 16;

    localparam logic [11:0] PcStart = 12'h200;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_EXEC  = 2'd1;
    localparam logic [1:0] REQ_ROW   = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] mem_address;
        logic [7:0]  mem_data;
        logic [15:0] key_mask;
        logic [7:0]  random_byte;
        logic [4:0]  row_index;
    } in_item_t;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [15:0] executed_opcode;
        logic        draw_flag;
        logic        waiting_for_key;
        logic        unknown_opcode;
        logic [7:0]  sound_level;
        logic [63:0] pixel_row;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ROWRD,
        ST_ROWOUT,
        ST_FETCH_HI,
        ST_FETCH_LO,
        ST_FETCH_WAIT,
        ST_DECODE,
        ST_EXEC,
        ST_DRAW_RD,
        ST_DRAW_WAIT,
        ST_DRAW_ROW,
        ST_DRAW_WR,
        ST_BCD,
        ST_STORE,
        ST_LOAD_RD,
        ST_LOAD_WAIT,
        ST_LOAD_WR,
        ST_DONE
    } state_t;

endpackage

/* hw/rtl/chip8_instruction_executor.sv */
// chip8 instruction executor top level: sequencer, register file, memory and display
//
// One item is one request: a memory byte write, a display row read or the execution of one
// instruction. A draw reads a sprite byte and the display row, merges them and writes the
// row back, one sprite row after another; Fx55 stores one register at a time, Fx65 reads and
// loads one register at a time and Fx33 writes three digit bytes. The program memory has one
// read port and the display reads one row at a time. After reset a clearing pass zeroes all
// 32 display rows before the first item is taken; 00E0 runs the same pass. The block takes
// no item while one is in work, and the result stays in an output register until taken.
module chip8_instruction_executor #(
    parameter int STACK_DEPTH = c8x_pkg::StackDepth
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  c8x_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output c8x_pkg::out_item_t  out_item
);

    localparam int SpW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int MemAw = $clog2(c8x_pkg::MemoryBytes);
    localparam int RowAw = $clog2(c8x_pkg::ScreenHeight);

    logic [7:0]  mem [c8x_pkg::MemoryBytes];
    logic [63:0] disp [c8x_pkg::ScreenHeight];

    c8x_pkg::state_t state_reg, state_next;

    c8x_pkg::in_item_t req_reg, req_next;
    logic [7:0]  v_reg [16];
    logic [7:0]  v_next [16];
    logic [11:0] stk_reg [STACK_DEPTH];
    logic [SpW-1:0] sp_reg, sp_next;
    logic [11:0] pc_reg, pc_next;
    logic [15:0] i_reg, i_next;
    logic [7:0]  dt_reg, dt_next, st_reg, st_next;
    logic [15:0] op_reg, op_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        hit_reg, hit_next;
    logic [7:0]  bcd_reg, bcd_next;
    logic        fdraw_reg, fdraw_next, fwait_reg, fwait_next, funk_reg, funk_next;
    logic [63:0] row_reg, row_next;
    logic        ovalid_reg, ovalid_next;
    c8x_pkg::out_item_t oitem_reg, oitem_next;

    // memory port
    logic        mem_we;
    logic [MemAw-1:0] mem_wa, mem_ra;
    logic [7:0]  mem_wd, mem_rd_reg;
    // display port
    logic        disp_we;
    logic [RowAw-1:0] disp_wa, disp_ra;
    logic [63:0] disp_wd, disp_rd_reg;
    // stack port
    logic        stk_we;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_rd_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk)
    begin
        if (disp_we)
        begin
            disp[disp_wa] <= disp_wd;
        end
        disp_rd_reg <= disp[disp_ra];
    end

    // decode
    logic [3:0] ox, oy, on;
    logic [7:0] okk, vx, vy;
    logic [11:0] onnn;
    assign ox = op_reg[11:8];
    assign oy = op_reg[7:4];
    assign on = op_reg[3:0];
    assign okk = op_reg[7:0];
    assign onnn = op_reg[11:0];
    assign vx = v_reg[ox];
    assign vy = v_reg[oy];

    // vf is written before vx in sub, subn and shifts
    logic [7:0] alu_vf, alu_x, alu_y;
    always_comb
    begin
        case (on)
            4'h5:    alu_vf = {7'd0, vx >= vy};
            4'h6:    alu_vf = {7'd0, vx[0]};
            4'h7:    alu_vf = {7'd0, vy >= vx};
            4'hE:    alu_vf = {7'd0, vx[7]};
            default: alu_vf = 8'd0;
        endcase
    end
    assign alu_x = (ox == 4'hF) ? alu_vf : vx;
    assign alu_y = (oy == 4'hF) ? alu_vf : vy;

    // shared adder
    logic [16:0] add_a, add_b, add_s;
    assign add_s = add_a + add_b;

    logic [15:0] idx_off;
    assign idx_off = i_reg + {11'd0, cnt_reg};

    logic [SpW-1:0] sp_dec;
    assign sp_dec = (sp_reg == '0) ? SpW'(STACK_DEPTH - 1) : sp_reg - 1'b1;

    logic key_down;
    assign key_down = (vx < 8'd16) && req_reg.key_mask[vx[3:0]];

    logic [3:0] hi_key;
    logic any_key;
    always_comb
    begin
        hi_key = '0;
        any_key = 1'b0;
        for (int k = 0; k < 16; k++)
        begin
            if (req_reg.key_mask[k])
            begin
                hi_key = 4'(k);
                any_key = 1'b1;
            end
        end
    end

    // tens digit by reciprocal multiplication
    logic [15:0] bcd_prod;
    logic [3:0]  bcd_tens;
    logic [7:0]  bcd_tens10;
    assign bcd_prod = {8'd0, bcd_reg} * 16'd205;
    assign bcd_tens = bcd_prod[14:11];
    assign bcd_tens10 = {1'b0, bcd_tens, 3'd0} + {3'd0, bcd_tens, 1'b0};

    // sprite row rotated into position
    logic [5:0]  vx6;
    logic [63:0] spr_mask;
    logic [63:0] spr_base;
    assign vx6 = vx[5:0];
    assign spr_base = {mem_rd_reg, 56'd0};
    assign spr_mask = (spr_base >> vx6) | (spr_base << (7'd64 - {1'b0, vx6}));

    logic [4:0] draw_row;
    assign draw_row = 5'(vy + {4'd0, cnt_reg[3:0]});

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            c8x_pkg::ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    case (in_item.req_type)
                        c8x_pkg::REQ_EXEC: state_next = c8x_pkg::ST_FETCH_HI;
                        c8x_pkg::REQ_ROW:  state_next = c8x_pkg::ST_ROWRD;
                        default:           state_next = c8x_pkg::ST_DONE;
                    endcase
                end
            end
            c8x_pkg::ST_CLEAR:
            begin
                if (cnt_reg == 5'(c8x_pkg::ScreenHeight - 1))
                begin
                    state_next = (ovalid_reg || op_reg == '0) ? c8x_pkg::ST_IDLE
                                                               : c8x_pkg::ST_DONE;
                end
            end
            c8x_pkg::ST_ROWRD:      state_next = c8x_pkg::ST_ROWOUT;
            c8x_pkg::ST_ROWOUT:     state_next = c8x_pkg::ST_DONE;
            c8x_pkg::ST_FETCH_HI:   state_next = c8x_pkg::ST_FETCH_LO;
            c8x_pkg::ST_FETCH_LO:   state_next = c8x_pkg::ST_FETCH_WAIT;
            c8x_pkg::ST_FETCH_WAIT: state_next = c8x_pkg::ST_DECODE;
            c8x_pkg::ST_DECODE:     state_next = c8x_pkg::ST_EXEC;
            c8x_pkg::ST_EXEC:
            begin
                state_next = c8x_pkg::ST_DONE;
                case (op_reg[15:12])
                    4'h0: if (op_reg == 16'h00E0) state_next = c8x_pkg::ST_CLEAR;
                    4'hD:
                    begin
                        if (on != 4'd0) state_next = c8x_pkg::ST_DRAW_RD;
                    end
                    4'hF:
                    begin
                        case (okk)
                            8'h33: state_next = c8x_pkg::ST_BCD;
                            8'h55: state_next = c8x_pkg::ST_STORE;
                            8'h65: state_next = c8x_pkg::ST_LOAD_RD;
                            default: state_next = c8x_pkg::ST_DONE;
                        endcase
                    end
                    default: state_next = c8x_pkg::ST_DONE;
                endcase
            end
            c8x_pkg::ST_DRAW_RD:   state_next = c8x_pkg::ST_DRAW_WAIT;
            c8x_pkg::ST_DRAW_WAIT: state_next = c8x_pkg::ST_DRAW_ROW;
            c8x_pkg::ST_DRAW_ROW:  state_next = c8x_pkg::ST_DRAW_WR;
            c8x_pkg::ST_DRAW_WR:
            begin
                state_next = (cnt_reg + 5'd1 == {1'b0, on}) ? c8x_pkg::ST_DONE
                                                             : c8x_pkg::ST_DRAW_RD;
            end
            c8x_pkg::ST_BCD:
            begin
                if (cnt_reg == 5'd2) state_next = c8x_pkg::ST_DONE;
            end
            c8x_pkg::ST_STORE:
            begin
                if (cnt_reg[3:0] == ox) state_next = c8x_pkg::ST_DONE;
            end
            c8x_pkg::ST_LOAD_RD:   state_next = c8x_pkg::ST_LOAD_WAIT;
            c8x_pkg::ST_LOAD_WAIT: state_next = c8x_pkg::ST_LOAD_WR;
            c8x_pkg::ST_LOAD_WR:
            begin
                state_next = (cnt_reg[3:0] == ox) ? c8x_pkg::ST_DONE : c8x_pkg::ST_LOAD_RD;
            end
            c8x_pkg::ST_DONE:       state_next = c8x_pkg::ST_IDLE;
            default:                state_next = c8x_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        req_next = req_reg;
        for (int k = 0; k < 16; k++)
        begin
            v_next[k] = v_reg[k];
        end
        sp_next = sp_reg;
        pc_next = pc_reg;
        i_next = i_reg;
        dt_next = dt_reg;
        st_next = st_reg;
        op_next = op_reg;
        cnt_next = cnt_reg;
        hit_next = hit_reg;
        bcd_next = bcd_reg;
        fdraw_next = fdraw_reg;
        fwait_next = fwait_reg;
        funk_next = funk_reg;
        row_next = row_reg;
        ovalid_next = ovalid_reg;
        oitem_next = oitem_reg;
        mem_we = 1'b0;
        mem_wa = req_reg.mem_address;
        mem_wd = req_reg.mem_data;
        mem_ra = pc_reg;
        disp_we = 1'b0;
        disp_wa = cnt_reg;
        disp_wd = '0;
        disp_ra = req_reg.row_index;
        stk_we = 1'b0;
        add_a = {9'd0, vx};
        add_b = {9'd0, vy};

        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            c8x_pkg::ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    req_next = in_item;
                    op_next = '0;
                    row_next = '0;
                    fdraw_next = 1'b0;
                    fwait_next = 1'b0;
                    funk_next = 1'b0;
                    cnt_next = '0;
                    hit_next = 1'b0;
                    if (in_item.req_type == c8x_pkg::REQ_WRITE)
                    begin
                        mem_we = 1'b1;
                        mem_wa = in_item.mem_address;
                        mem_wd = in_item.mem_data;
                    end
                end
            end
            c8x_pkg::ST_CLEAR:
            begin
                disp_we = 1'b1;
                disp_wa = cnt_reg;
                disp_wd = '0;
                cnt_next = cnt_reg + 5'd1;
            end
            c8x_pkg::ST_ROWRD:
            begin
                disp_ra = req_reg.row_index;
            end
            c8x_pkg::ST_ROWOUT:
            begin
                row_next = disp_rd_reg;
            end
            c8x_pkg::ST_FETCH_HI:
            begin
                mem_ra = pc_reg;
            end
            c8x_pkg::ST_FETCH_LO:
            begin
                mem_ra = pc_reg + 12'd1;
                op_next = {mem_rd_reg, 8'd0};
            end
            c8x_pkg::ST_FETCH_WAIT:
            begin
                op_next = {op_reg[15:8], mem_rd_reg};
            end
            c8x_pkg::ST_DECODE:
            begin
                disp_ra = draw_row;
            end
            c8x_pkg::ST_EXEC:
            begin
                case (op_reg[15:12])
                    4'h0:
                    begin
                        if (op_reg == 16'h00E0)
                        begin
                            fdraw_next = 1'b1;
                            cnt_next = '0;
                            pc_next = pc_reg + 12'd2;
                        end
                        else if (op_reg == 16'h00EE)
                        begin
                            sp_next = sp_dec;
                            pc_next = stk_reg[sp_dec] + 12'd2;
                        end
                        else
                        begin
                            funk_next = 1'b1;
                        end
                    end
                    4'h1: pc_next = onnn;
                    4'h2:
                    begin
                        stk_we = 1'b1;
                        sp_next = (sp_reg == SpW'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;
                        pc_next = onnn;
                    end
                    4'h3: pc_next = pc_reg + ((vx == okk) ? 12'd4 : 12'd2);
                    4'h4: pc_next = pc_reg + ((vx != okk) ? 12'd4 : 12'd2);
                    4'h5: pc_next = pc_reg + ((vx == vy) ? 12'd4 : 12'd2);
                    4'h6:
                    begin
                        v_next[ox] = okk;
                        pc_next = pc_reg + 12'd2;
                    end
                    4'h7:
                    begin
                        add_b = {9'd0, okk};
                        v_next[ox] = add_s[7:0];
                        pc_next = pc_reg + 12'd2;
                    end
                    4'h8:
                    begin
                        pc_next = pc_reg + 12'd2;
                        case (on)
                            4'h0: v_next[ox] = vy;
                            4'h1: v_next[ox] = vx | vy;
                            4'h2: v_next[ox] = vx & vy;
                            4'h3: v_next[ox] = vx ^ vy;
                            4'h4:
                            begin
                                v_next[ox] = add_s[7:0];
                                v_next[15] = {7'd0, add_s[8]};
                            end
                            4'h5:
                            begin
                                add_a = {9'd0, alu_x};
                                add_b = {9'd0, ~alu_y} + 17'd1;
                                v_next[15] = alu_vf;
                                v_next[ox] = add_s[7:0];
                            end
                            4'h6:
                            begin
                                v_next[15] = alu_vf;
                                v_next[ox] = {1'b0, alu_x[7:1]};
                            end
                            4'h7:
                            begin
                                add_a = {9'd0, alu_y};
                                add_b = {9'd0, ~alu_x} + 17'd1;
                                v_next[15] = alu_vf;
                                v_next[ox] = add_s[7:0];
                            end
                            4'hE:
                            begin
                                v_next[15] = alu_vf;
                                v_next[ox] = {alu_x[6:0], 1'b0};
                            end
                            default:
                            begin
                                funk_next = 1'b1;
                                pc_next = pc_reg;
                            end
                        endcase
                    end
                    4'h9: pc_next = pc_reg + ((vx != vy) ? 12'd4 : 12'd2);
                    4'hA:
                    begin
                        i_next = {4'd0, onnn};
                        pc_next = pc_reg + 12'd2;
                    end
                    4'hB:
                    begin
                        add_a = {5'd0, onnn};
                        add_b = {9'd0, v_reg[0]};
                        pc_next = add_s[11:0];
                    end
                    4'hC:
                    begin
                        v_next[ox] = req_reg.random_byte & okk;
                        pc_next = pc_reg + 12'd2;
                    end
                    4'hD:
                    begin
                        fdraw_next = 1'b1;
                        cnt_next = '0;
                        hit_next = 1'b0;
                        pc_next = pc_reg + 12'd2;
                        if (on == 4'd0)
                        begin
                            v_next[15] = 8'd0;
                        end
                    end
                    4'hE:
                    begin
                        if (okk == 8'h9E)
                        begin
                            pc_next = pc_reg + (key_down ? 12'd4 : 12'd2);
                        end
                        else if (okk == 8'hA1)
                        begin
                            pc_next = pc_reg + (key_down ? 12'd2 : 12'd4);
                        end
                        else
                        begin
                            funk_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        pc_next = pc_reg + 12'd2;
                        cnt_next = '0;
                        case (okk)
                            8'h07: v_next[ox] = dt_reg;
                            8'h0A:
                            begin
                                if (any_key)
                                begin
                                    v_next[ox] = {4'd0, hi_key};
                                end
                                else
                                begin
                                    fwait_next = 1'b1;
                                    pc_next = pc_reg;
                                end
                            end
                            8'h15: dt_next = vx;
                            8'h18: st_next = vx;
                            8'h1E:
                            begin
                                add_a = {1'b0, i_reg};
                                add_b = {9'd0, vx};
                                v_next[15] = {7'd0, add_s[16:12] != 5'd0};
                                i_next = add_s[15:0];
                            end
                            8'h29:
                            begin
                                add_a = {7'd0, vx, 2'd0};
                                add_b = {9'd0, vx};
                                i_next = add_s[15:0];
                            end
                            8'h33: bcd_next = vx;
                            8'h55, 8'h65: ;
                            default:
                            begin
                                funk_next = 1'b1;
                                pc_next = pc_reg;
                            end
                        endcase
                    end
                endcase
            end
            c8x_pkg::ST_DRAW_RD:
            begin
                mem_ra = idx_off[11:0];
                disp_ra = draw_row;
            end
            c8x_pkg::ST_DRAW_WAIT:
            begin
                mem_ra = idx_off[11:0];
                disp_ra = draw_row;
            end
            c8x_pkg::ST_DRAW_ROW:
            begin
                disp_ra = draw_row;
                row_next = spr_mask;
                if ((disp_rd_reg & spr_mask) != '0)
                begin
                    hit_next = 1'b1;
                end
            end
            c8x_pkg::ST_DRAW_WR:
            begin
                disp_we = 1'b1;
                disp_wa = draw_row;
                disp_wd = disp_rd_reg ^ row_reg;
                row_next = '0;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg + 5'd1 == {1'b0, on})
                begin
                    v_next[15] = {7'd0, hit_reg};
                end
            end
            c8x_pkg::ST_BCD:
            begin
                mem_we = 1'b1;
                mem_wa = idx_off[11:0];
                if (cnt_reg == 5'd0)
                begin
                    if (bcd_reg >= 8'd200)
                    begin
                        mem_wd = 8'd2;
                        bcd_next = bcd_reg - 8'd200;
                    end
                    else if (bcd_reg >= 8'd100)
                    begin
                        mem_wd = 8'd1;
                        bcd_next = bcd_reg - 8'd100;
                    end
                    else
                    begin
                        mem_wd = 8'd0;
                    end
                end
                else if (cnt_reg == 5'd1)
                begin
                    mem_wd = {4'd0, bcd_tens};
                    bcd_next = bcd_reg - bcd_tens10;
                end
                else
                begin
                    mem_wd = bcd_reg;
                end
                cnt_next = cnt_reg + 5'd1;
            end
            c8x_pkg::ST_STORE:
            begin
                mem_we = 1'b1;
                mem_wa = idx_off[11:0];
                mem_wd = v_reg[cnt_reg[3:0]];
                cnt_next = cnt_reg + 5'd1;
            end
            c8x_pkg::ST_LOAD_RD:
            begin
                mem_ra = idx_off[11:0];
            end
            c8x_pkg::ST_LOAD_WAIT:
            begin
                mem_ra = idx_off[11:0];
            end
            c8x_pkg::ST_LOAD_WR:
            begin
                v_next[cnt_reg[3:0]] = mem_rd_reg;
                cnt_next = cnt_reg + 5'd1;
            end
            c8x_pkg::ST_DONE:
            begin
                ovalid_next = 1'b1;
                oitem_next.program_counter = pc_reg;
                oitem_next.executed_opcode = op_reg;
                oitem_next.draw_flag = fdraw_reg;
                oitem_next.waiting_for_key = fwait_reg;
                oitem_next.unknown_opcode = funk_reg;
                oitem_next.sound_level = st_reg;
                oitem_next.pixel_row = row_reg;
            end
            default: ;
        endcase
    end

    // 00E0 sets ovalid via op; reset pass uses op_reg zero with no pending result
    assign in_stall = (state_reg != c8x_pkg::ST_IDLE) || ovalid_reg;
    assign out_valid = ovalid_reg;
    assign out_item = oitem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= c8x_pkg::ST_CLEAR;
            for (int k = 0; k < 16; k++)
            begin
                v_reg[k] <= '0;
            end
            for (int k = 0; k < STACK_DEPTH; k++)
            begin
                stk_reg[k] <= '0;
            end
            sp_reg <= '0;
            pc_reg <= c8x_pkg::PcStart;
            i_reg <= '0;
            dt_reg <= '0;
            st_reg <= '0;
            op_reg <= '0;
            cnt_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            for (int k = 0; k < 16; k++)
            begin
                v_reg[k] <= v_next[k];
            end
            if (stk_we)
            begin
                stk_reg[sp_reg] <= pc_reg;
            end
            sp_reg <= sp_next;
            pc_reg <= pc_next;
            i_reg <= i_next;
            dt_reg <= dt_next;
            st_reg <= st_next;
            op_reg <= op_next;
            cnt_reg <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        hit_reg <= hit_next;
        bcd_reg <= bcd_next;
        fdraw_reg <= fdraw_next;
        fwait_reg <= fwait_next;
        funk_reg <= funk_next;
        row_reg <= row_next;
        oitem_reg <= oitem_next;
    end

endmodule
